/* src/srfpll_pkg.sv */
// Shared types, constants and sine table builder for the three-phase SRF PLL.
package srfpll_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);
    localparam int SAMPLE_W         = 16;
    localparam int OUT_W            = 160;

    localparam logic [31:0] THIRD_TURN     = 32'd1431655765;
    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
    // floor(y / 3) = (y * DIV3_RECIP) >> DIV3_SHIFT for y < 2^19
    localparam logic [19:0] DIV3_RECIP     = 20'd349526;
    localparam int          DIV3_SHIFT     = 20;

    localparam logic [31:0] STEP_TIME_RST = 32'd42950;
    localparam logic [31:0] PROP_GAIN_RST = 32'd13107200;
    localparam logic [31:0] INT_GAIN_RST  = 32'd1310720000;

    localparam logic [1:0] CFG_STEP_TIME = 2'd0;
    localparam logic [1:0] CFG_PROP_GAIN = 2'd1;
    localparam logic [1:0] CFG_INT_GAIN  = 2'd2;

    typedef logic [15:0] sine_rom_t [SINE_TABLE_DEPTH];

    typedef enum logic [4:0] {
        S_IDLE,
        S_SIN0,
        S_SIN1,
        S_SIN2,
        S_SIN3,
        S_SUM,
        S_DIV,
        S_ERR,
        S_INC,
        S_INTEG,
        S_PTERM,
        S_IHI,
        S_ILO,
        S_OMEGA,
        S_FREQ,
        S_SUMW,
        S_Q1,
        S_Q2,
        S_ANG
    } state_t;

    // quarter-wave sine, Q1.15, entry i = sin((pi/2)*(i+1/2)/depth), Taylor series in Q30
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] s;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            x    = (HALF_PI_Q30 * 64'(2 * i + 1)) / 64'(2 * SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            s    = signed'(x);
            for (int k = 1; k <= 5; k++)
            begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    s = s - signed'(term);
                else
                    s = s + signed'(term);
            end
            if (s < 0)
                s = 0;
            s = (s + 64'sd16384) >>> 15;
            if (s > 64'sd32767)
                s = 64'sd32767;
            rom[i] = s[15:0];
        end
        return rom;
    endfunction

endpackage

/* src/srfpll_sine.sv */
// Quarter-wave sine ROM with quadrant mirroring and sign; the ROM read is registered.
module srfpll_sine
    import srfpll_pkg::*;
(
    input  logic               clk,
    input  logic [31:0]        phase,
    output logic signed [15:0] sine
);

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic [SINE_ADDR_W+1:0] pos;
    logic [1:0]             quad;
    logic [SINE_ADDR_W-1:0] idx;
    logic [15:0]            rom_data_reg;
    logic                   neg_reg;

    assign pos  = phase[31 -: SINE_ADDR_W + 2];
    assign quad = pos[SINE_ADDR_W+1:SINE_ADDR_W];
    assign idx  = quad[0] ? ~pos[SINE_ADDR_W-1:0] : pos[SINE_ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        rom_data_reg <= SINE_ROM[idx];
        neg_reg      <= quad[1];
    end

    assign sine = neg_reg ? -signed'(rom_data_reg) : signed'(rom_data_reg);

endmodule

/* src/three_phase_srf_pll.sv */
// Three-phase SRF PLL top level: sequencer around one shared 34x34 multiplier.
//
// channel  dir  handshake                      payload
// s_axis   in   s_axis_tvalid/s_axis_tready    tdata: phase_a, phase_b, phase_c
// m_axis   out  m_axis_tvalid/m_axis_tready    tdata: angle, omega_out, frequency,
//                                              d_error, error_integral_out
// cfg      in   cfg_wr_en                      cfg_index, cfg_wdata
//
// An item passes through the sequencer states SIN0 to ANG from acceptance to result; the
// next item can be taken only once the sequencer is back in idle. The shared multiplier
// forms 12 products and the sine ROM read is registered.
// s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register; the last step waits there only if a
// previous result has not been taken.
// Reset clears the loop state and loads the register defaults.
module three_phase_srf_pll
    import srfpll_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [3*SAMPLE_W-1:0] s_axis_tdata,  // phase_a, phase_b, phase_c
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata,  // angle, omega_out, frequency, d_error, error_integral_out
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wdata
);

    state_t state_reg;
    state_t state_next;

    logic [31:0]        step_time_reg;
    logic [31:0]        prop_gain_reg;
    logic [31:0]        int_gain_reg;
    logic [31:0]        angle_acc_reg;
    logic signed [15:0] prev_error_reg;
    logic signed [47:0] error_integral_reg;
    logic signed [31:0] prev_omega_reg;
    logic               m_valid_reg;
    logic [OUT_W-1:0]   m_data_reg;

    logic signed [15:0] a_reg;
    logic signed [15:0] b_reg;
    logic signed [15:0] c_reg;
    logic signed [67:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic               dneg_reg;
    logic signed [15:0] err_reg;
    logic signed [47:0] integ_reg;
    logic signed [32:0] pterm_reg;
    logic signed [31:0] omega_reg;
    logic signed [31:0] freq_reg;
    logic [32:0]        smag_reg;
    logic               sneg_reg;
    logic [15:0]        low_reg;

    logic [31:0]        sine_phase;
    logic signed [15:0] sine;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;

    logic               accept;
    logic               out_free;
    logic               advance;
    logic [35:0]        sum_mag;
    logic [18:0]        div_in;
    logic [16:0]        div_q;
    logic signed [15:0] err_val;
    logic signed [16:0] err_pair;
    logic signed [41:0] inc_val;
    logic signed [48:0] integ_sum;
    logic signed [47:0] integ_val;
    logic signed [41:0] iterm;
    logic signed [42:0] omega_sum;
    logic signed [31:0] omega_val;
    logic signed [32:0] omega_pair;
    logic signed [67:0] freq_sum;
    logic [63:0]        q_sum;
    logic [31:0]        delta;

    srfpll_sine u_sine
    (
        .clk   (clk),
        .phase (sine_phase),
        .sine  (sine)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign advance       = (state_reg == S_ANG) && out_free;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb
    begin
        state_next = state_reg;
        sine_phase = angle_acc_reg;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_SIN0;
            end
            S_SIN0:
            begin
                state_next = S_SIN1;
            end
            S_SIN1:
            begin
                sine_phase = angle_acc_reg - THIRD_TURN;
                mul_a      = 34'(a_reg);
                mul_b      = 34'(sine);
                state_next = S_SIN2;
            end
            S_SIN2:
            begin
                sine_phase = angle_acc_reg + THIRD_TURN;
                mul_a      = 34'(b_reg);
                mul_b      = 34'(sine);
                state_next = S_SIN3;
            end
            S_SIN3:
            begin
                mul_a      = 34'(c_reg);
                mul_b      = 34'(sine);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                mul_a      = {15'b0, div_in};
                mul_b      = {14'b0, DIV3_RECIP};
                state_next = S_ERR;
            end
            S_ERR:
            begin
                state_next = S_INC;
            end
            S_INC:
            begin
                mul_a      = {2'b00, step_time_reg};
                mul_b      = 34'(err_pair);
                state_next = S_INTEG;
            end
            S_INTEG:
            begin
                mul_a      = {2'b00, prop_gain_reg};
                mul_b      = 34'(err_reg);
                state_next = S_PTERM;
            end
            S_PTERM:
            begin
                mul_a      = {2'b00, int_gain_reg};
                mul_b      = 34'($signed(integ_reg[47:24]));
                state_next = S_IHI;
            end
            S_IHI:
            begin
                mul_a      = {2'b00, int_gain_reg};
                mul_b      = {10'b0, integ_reg[23:0]};
                state_next = S_ILO;
            end
            S_ILO:
            begin
                state_next = S_OMEGA;
            end
            S_OMEGA:
            begin
                state_next = S_FREQ;
            end
            S_FREQ:
            begin
                mul_a      = 34'(omega_reg);
                mul_b      = {2'b00, INV_TWO_PI_Q32};
                state_next = S_SUMW;
            end
            S_SUMW:
            begin
                mul_a      = {1'b0, smag_reg};
                mul_b      = {2'b00, step_time_reg};
                state_next = S_Q1;
            end
            S_Q1:
            begin
                mul_a      = {2'b00, prod_reg[64:33]};
                mul_b      = {2'b00, INV_TWO_PI_Q32};
                state_next = S_Q2;
            end
            S_Q2:
            begin
                mul_a      = {18'b0, low_reg};
                mul_b      = {2'b00, INV_TWO_PI_Q32};
                state_next = S_ANG;
            end
            S_ANG:
            begin
                // operands held so the product stays put while the output is stalled
                mul_a = {18'b0, low_reg};
                mul_b = {2'b00, INV_TWO_PI_Q32};
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // d value: round(|2*sum| / (3*2^15)), split as a shift then a divide by three
    assign sum_mag = acc_reg[63] ? 36'(-acc_reg) : 36'(acc_reg);
    assign div_in  = 19'(((37'(sum_mag) << 1) + 37'd49152) >> 15);
    assign div_q   = prod_reg[DIV3_SHIFT+16:DIV3_SHIFT];

    always_comb
    begin
        if (dneg_reg)
            err_val = (div_q > 17'd32767) ? 16'sh7FFF : signed'(div_q[15:0]);
        else
            err_val = (div_q > 17'd32768) ? 16'sh8000 : signed'(16'(-div_q));
    end

    assign err_pair  = 17'(err_reg) + 17'(prev_error_reg);
    assign inc_val   = prod_reg[49:8];
    assign integ_sum = 49'(error_integral_reg) + 49'(inc_val);
    assign integ_val = (integ_sum[48] != integ_sum[47])
                     ? (integ_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}})
                     : integ_sum[47:0];

    assign iterm     = acc_reg[57:16];
    assign omega_sum = 43'(pterm_reg) + 43'(iterm);
    assign omega_val = (omega_sum[42:31] != {12{omega_sum[31]}})
                     ? (omega_sum[42] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}})
                     : omega_sum[31:0];

    assign omega_pair = 33'(omega_reg) + 33'(prev_omega_reg);
    assign freq_sum   = prod_reg + 68'sd2147483648;
    assign q_sum      = acc_reg + {16'b0, prod_reg[63:16]};
    assign delta      = q_sum[47:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            step_time_reg      <= STEP_TIME_RST;
            prop_gain_reg      <= PROP_GAIN_RST;
            int_gain_reg       <= INT_GAIN_RST;
            angle_acc_reg      <= '0;
            prev_error_reg     <= '0;
            error_integral_reg <= '0;
            prev_omega_reg     <= '0;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_STEP_TIME: step_time_reg <= cfg_wdata;
                    CFG_PROP_GAIN: prop_gain_reg <= cfg_wdata;
                    CFG_INT_GAIN:  int_gain_reg  <= cfg_wdata;
                    default:       ;
                endcase
            end
            if (advance)
            begin
                angle_acc_reg      <= sneg_reg ? angle_acc_reg - delta : angle_acc_reg + delta;
                prev_error_reg     <= err_reg;
                error_integral_reg <= integ_reg;
                prev_omega_reg     <= omega_reg;
                m_valid_reg        <= 1'b1;
            end
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 68'(mul_a) * 68'(mul_b);
        if (accept)
        begin
            a_reg <= s_axis_tdata[15:0];
            b_reg <= s_axis_tdata[31:16];
            c_reg <= s_axis_tdata[47:32];
        end
        unique case (state_reg)
            S_SIN2:  acc_reg <= 64'(prod_reg);
            S_SIN3:  acc_reg <= acc_reg + 64'(prod_reg);
            S_SUM:   acc_reg <= acc_reg + 64'(prod_reg);
            S_DIV:   dneg_reg <= acc_reg[63];
            S_ERR:   err_reg <= err_val;
            S_INTEG: integ_reg <= integ_val;
            S_PTERM: pterm_reg <= prod_reg[47:15];
            S_IHI:   acc_reg <= 64'(prod_reg);
            S_ILO:   acc_reg <= acc_reg + {32'b0, prod_reg[55:24]};
            S_OMEGA: omega_reg <= omega_val;
            S_FREQ:
            begin
                sneg_reg <= omega_pair[32];
                smag_reg <= omega_pair[32] ? 33'(-omega_pair) : 33'(omega_pair);
            end
            S_SUMW:  freq_reg <= freq_sum[63:32];
            S_Q1:    low_reg <= prod_reg[32:17];
            S_Q2:    acc_reg <= 64'(prod_reg);
            S_ANG:
            begin
                if (advance)
                    m_data_reg <= {integ_reg, err_reg, freq_reg, omega_reg,
                                   sneg_reg ? angle_acc_reg - delta : angle_acc_reg + delta};
            end
            default: ;
        endcase
    end

endmodule

/* src/srfpll_check.sv */
// Port-level assertions for the three-phase SRF PLL, bound to the top level.
module srfpll_check
    import srfpll_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_W-1:0]      m_axis_tdata
);

    // busy after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while busy");

    // a new result appears only together with the sequencer's return to idle
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result without return to idle");

    // non-negative omega never gives a negative frequency
    a_freq_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[63]) |-> !m_axis_tdata[95])
        else $error("frequency sign disagrees with omega");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind three_phase_srf_pll srfpll_check u_srfpll_check (.*);
